[hw/rtl/lsu_pkg.sv]
// Shared types and constants of the load/store unit stage.
package lsu_pkg;

    // Access kind codes carried in req_type.
    localparam logic [3:0] KIND_NONE = 4'd0;
    localparam logic [3:0] KIND_LW   = 4'd1;
    localparam logic [3:0] KIND_LH   = 4'd2;
    localparam logic [3:0] KIND_LHU  = 4'd3;
    localparam logic [3:0] KIND_LB   = 4'd4;
    localparam logic [3:0] KIND_LBU  = 4'd5;
    localparam logic [3:0] KIND_SW   = 4'd6;
    localparam logic [3:0] KIND_SH   = 4'd7;
    localparam logic [3:0] KIND_SB   = 4'd8;

    localparam int LANES = 4;

    typedef struct packed {
        logic        downstream_ready;
        logic        upstream_busy;
        logic        inst_valid;
        logic [3:0]  req_type;
        logic [15:0] address;
        logic [31:0] store_data;
        logic [31:0] pass_result;
    } lsu_in_t;

    typedef struct packed {
        logic        buffer_written;
        logic        out_inst_valid;
        logic [3:0]  out_req_type;
        logic [31:0] out_result;
        logic        stage_busy;
        logic        stage_ready;
    } lsu_out_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } lsu_state_t;

endpackage

[hw/rtl/lsu_if.sv]
// Valid/ready channel interfaces for the input and result transactions.
interface lsu_in_if;
    logic             valid;
    logic             ready;
    lsu_pkg::lsu_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lsu_out_if;
    logic              valid;
    logic              ready;
    lsu_pkg::lsu_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/lsu_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module lsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/lsu_lane_map.sv]
// Maps a byte address and access size onto the four byte-lane RAMs.
module lsu_lane_map #(
    parameter int AW = 16
) (
    input  logic [15:0]                    address,
    input  logic [3:0]                     req_type,
    input  logic [31:0]                    store_data,
    output logic [lsu_pkg::LANES-1:0]      lane_used,
    output logic [lsu_pkg::LANES-1:0][AW-3:0] lane_row,
    output logic [lsu_pkg::LANES-1:0][7:0] lane_wdata
);

    logic [2:0] nbytes;

    always_comb
    begin
        case (req_type)
            lsu_pkg::KIND_LW, lsu_pkg::KIND_SW:                   nbytes = 3'd4;
            lsu_pkg::KIND_LH, lsu_pkg::KIND_LHU, lsu_pkg::KIND_SH: nbytes = 3'd2;
            lsu_pkg::KIND_LB, lsu_pkg::KIND_LBU, lsu_pkg::KIND_SB: nbytes = 3'd1;
            default:                                              nbytes = 3'd0;
        endcase
    end

    // Lane j holds the byte at offset k where (address + k) mod 4 equals j.
    // Consecutive bytes fall in distinct lanes, so each lane sees at most one.
    always_comb
    begin
        logic [1:0]  k;
        logic [31:0] sum;
        for (int j = 0; j < lsu_pkg::LANES; j++)
        begin
            k             = 2'(j) - address[1:0];
            sum           = 32'(address) + 32'(k);
            lane_used[j]  = {1'b0, k} < nbytes;
            lane_row[j]   = sum[AW-1:2];
            lane_wdata[j] = store_data[8*k +: 8];
        end
    end

endmodule

[hw/rtl/lsu_load_align.sv]
// Gathers loaded bytes from the lanes and applies sign or zero extension.
module lsu_load_align (
    input  logic [lsu_pkg::LANES-1:0][7:0] lane_rdata,
    input  logic [1:0]                     addr_lo,
    input  logic [3:0]                     req_type,
    output logic [31:0]                    result
);

    logic [3:0][7:0] bytes;

    always_comb
    begin
        for (int k = 0; k < lsu_pkg::LANES; k++)
        begin
            bytes[k] = lane_rdata[addr_lo + 2'(k)];
        end
    end

    always_comb
    begin
        case (req_type)
            lsu_pkg::KIND_LW:  result = {bytes[3], bytes[2], bytes[1], bytes[0]};
            lsu_pkg::KIND_LH:  result = {{16{bytes[1][7]}}, bytes[1], bytes[0]};
            lsu_pkg::KIND_LHU: result = {16'd0, bytes[1], bytes[0]};
            lsu_pkg::KIND_LB:  result = {{24{bytes[0][7]}}, bytes[0]};
            lsu_pkg::KIND_LBU: result = {24'd0, bytes[0]};
            default:           result = 32'd0;
        endcase
    end

endmodule

[hw/rtl/load_store_unit_stage.sv]
// Memory stage of a pipelined RV32I core: each input transaction is one pipeline tick and
// yields exactly one result transaction. The byte memory is split into four byte-lane RAMs
// of MEM_BYTES/4 entries each (MEM_BYTES must be a power of two), so any aligned or
// unaligned access of up to four bytes touches each lane at most once; addresses wrap at
// MEM_BYTES. Memory contents are not initialized. Stores and non-load ticks write their
// result straight into the output register; a tick that performs a load first reads the
// lane RAMs, whose read data is registered, and its result is written from ST_LOAD. The
// stage works on one transaction at a time and takes the next one as soon as its output
// register is empty or being drained, except while in ST_LOAD, when the input is held off.
module load_store_unit_stage #(
    parameter int MEM_BYTES    = 65536,
    parameter int ACCESS_TICKS = 3
) (
    input logic     clk,
    input logic     rst_n,
    lsu_in_if.sink  req,
    lsu_out_if.source rsp
);

    localparam int AW    = $clog2(MEM_BYTES);
    localparam int ROWS  = MEM_BYTES / lsu_pkg::LANES;
    localparam int PW    = (ACCESS_TICKS > 1) ? $clog2(ACCESS_TICKS) : 1;

    lsu_pkg::lsu_state_t state_reg, state_next;
    logic [PW-1:0]       phase_reg, phase_next;
    logic                busy_reg, busy_next;
    logic                ready_reg, ready_next;
    logic                out_valid_reg, out_valid_next;
    lsu_pkg::lsu_out_t   out_data_reg, out_data_next;

    // Held across the read latency of a load.
    logic [3:0]          pend_kind_reg;
    logic                pend_valid_reg;
    logic [1:0]          pend_lo_reg;
    logic                pend_busy_reg;
    logic                pend_ready_reg;

    lsu_pkg::lsu_in_t    item;
    logic                accept;
    logic                p0, stall_dn, stall_up, bubble, access;
    logic                is_load, is_store;
    logic                do_load, do_store;
    logic [PW-1:0]       phase_adv;
    logic                busy_c, ready_c;
    lsu_pkg::lsu_out_t   item_out;

    logic [lsu_pkg::LANES-1:0]         lane_used;
    logic [lsu_pkg::LANES-1:0][AW-3:0] lane_row;
    logic [lsu_pkg::LANES-1:0][7:0]    lane_wdata;
    logic [lsu_pkg::LANES-1:0][7:0]    lane_rdata;
    logic [31:0]                       load_result;

    assign item      = req.data;
    assign req.ready = (state_reg == lsu_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        is_load  = item.req_type inside {[lsu_pkg::KIND_LW:lsu_pkg::KIND_LBU]};
        is_store = item.req_type inside {[lsu_pkg::KIND_SW:lsu_pkg::KIND_SB]};
    end

    // Stall checks only apply at the start of an access; inside one they are ignored.
    assign p0       = (phase_reg == '0);
    assign stall_dn = p0 && !item.downstream_ready;
    assign stall_up = p0 && item.downstream_ready && item.upstream_busy;
    assign bubble   = p0 && item.downstream_ready && !item.upstream_busy && !item.inst_valid;
    assign access   = !(stall_dn || stall_up || bubble);
    assign do_load  = accept && access && is_load;
    assign do_store = accept && access && is_store;

    assign phase_adv = (phase_reg == PW'(ACCESS_TICKS - 1)) ? '0 : phase_reg + 1'b1;

    lsu_lane_map #(
        .AW (AW)
    ) u_lane_map (
        .address    (item.address),
        .req_type   (item.req_type),
        .store_data (item.store_data),
        .lane_used  (lane_used),
        .lane_row   (lane_row),
        .lane_wdata (lane_wdata)
    );

    for (genvar j = 0; j < lsu_pkg::LANES; j++)
    begin : g_lane
        lsu_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .clk   (clk),
            .en    ((do_load || do_store) && lane_used[j]),
            .we    (do_store),
            .addr  (lane_row[j]),
            .wdata (lane_wdata[j]),
            .rdata (lane_rdata[j])
        );
    end

    lsu_load_align u_align (
        .lane_rdata (lane_rdata),
        .addr_lo    (pend_lo_reg),
        .req_type   (pend_kind_reg),
        .result     (load_result)
    );

    always_comb
    begin
        phase_next = phase_reg;
        busy_c     = busy_reg;
        ready_c    = ready_reg;
        if (stall_dn)
        begin
            ready_c = 1'b0;
        end
        else if (stall_up)
        begin
            busy_c = 1'b1;
        end
        else if (bubble)
        begin
            busy_c = 1'b0;
        end
        else
        begin
            if (is_load || is_store)
            begin
                phase_next = phase_adv;
            end
            busy_c  = (phase_next != '0);
            ready_c = (phase_next == '0);
        end

        item_out.buffer_written = !(stall_dn || stall_up);
        item_out.out_inst_valid = item_out.buffer_written && item.inst_valid;
        item_out.out_req_type   = item_out.buffer_written ? item.req_type : lsu_pkg::KIND_NONE;
        item_out.out_result     = item_out.buffer_written ? item.pass_result : 32'd0;
        item_out.stage_busy     = busy_c;
        item_out.stage_ready    = ready_c;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        busy_next      = busy_reg;
        ready_next     = ready_reg;
        case (state_reg)
            lsu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    busy_next  = busy_c;
                    ready_next = ready_c;
                    if (do_load)
                    begin
                        state_next = lsu_pkg::ST_LOAD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = item_out;
                    end
                end
            end
            lsu_pkg::ST_LOAD:
            begin
                state_next                    = lsu_pkg::ST_IDLE;
                out_valid_next                = 1'b1;
                out_data_next.buffer_written  = 1'b1;
                out_data_next.out_inst_valid  = pend_valid_reg;
                out_data_next.out_req_type    = pend_kind_reg;
                out_data_next.out_result      = load_result;
                out_data_next.stage_busy      = pend_busy_reg;
                out_data_next.stage_ready     = pend_ready_reg;
            end
            default:
            begin
                state_next = lsu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsu_pkg::ST_IDLE;
            phase_reg     <= '0;
            busy_reg      <= 1'b0;
            ready_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (do_load)
        begin
            pend_kind_reg  <= item.req_type;
            pend_valid_reg <= item.inst_valid;
            pend_lo_reg    <= item.address[1:0];
            pend_busy_reg  <= busy_c;
            pend_ready_reg <= ready_c;
        end
    end

endmodule
